/* rtl/relay_port_timer_controller_macros.svh */
// Assertion macros for the relay port timer controller checker.
// The first expects signals named clock and reset in scope, the second only clock.
`ifndef RELAY_PORT_TIMER_CONTROLLER_MACROS_SVH
`define RELAY_PORT_TIMER_CONTROLLER_MACROS_SVH

// Check a property outside of reset.
`define RPTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RPTC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/rptc_pkg.sv */
// ----------------------------------------------------------------------------
// rptc_pkg
// Shared types and codes of the relay port timer controller.
// ----------------------------------------------------------------------------
package rptc_pkg;

   // input item kinds
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_MESSAGE = 1'b1;

   // message types
   localparam logic [3:0] MT_BUTTON      = 4'd0;
   localparam logic [3:0] MT_ON          = 4'd1;
   localparam logic [3:0] MT_OFF         = 4'd2;
   localparam logic [3:0] MT_QUERY       = 4'd3;
   localparam logic [3:0] MT_CFG_REQ     = 4'd4;
   localparam logic [3:0] MT_ALARM_SET   = 4'd5;
   localparam logic [3:0] MT_ALARM_INFO  = 4'd6;
   localparam logic [3:0] MT_DEV_STATES  = 4'd7;
   localparam logic [3:0] MT_MUTE_OFF    = 4'd8;
   localparam logic [3:0] MT_MUTE_ON     = 4'd9;

   // wake modes of an alarm set
   localparam logic [1:0] WAKE_ON  = 2'd1;
   localparam logic [1:0] WAKE_OFF = 2'd2;

   // reply kinds
   localparam logic [1:0] RK_BROADCAST   = 2'd0;
   localparam logic [1:0] RK_STATE_REPLY = 2'd1;
   localparam logic [1:0] RK_CFG_REPLY   = 2'd2;
   localparam logic [1:0] RK_ALARM_REPLY = 2'd3;

   // classified operations handed from front to back
   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_TICK        = 4'd1;
   localparam logic [3:0] OP_BUTTON      = 4'd2;
   localparam logic [3:0] OP_ON          = 4'd3;
   localparam logic [3:0] OP_OFF         = 4'd4;
   localparam logic [3:0] OP_QUERY       = 4'd5;
   localparam logic [3:0] OP_CFG_REQ     = 4'd6;
   localparam logic [3:0] OP_ALARM_SET   = 4'd7;
   localparam logic [3:0] OP_ALARM_INFO  = 4'd8;
   localparam logic [3:0] OP_STATE_REPLY = 4'd9;

   // mute actions
   localparam logic [1:0] MUTE_NONE  = 2'd0;
   localparam logic [1:0] MUTE_CLEAR = 2'd1;
   localparam logic [1:0] MUTE_SET   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_TIMER_CODE  = 3'd0;
   localparam logic [2:0] CSR_AUTO_OFF    = 3'd1;
   localparam logic [2:0] CSR_DELAYED_ON  = 3'd2;
   localparam logic [2:0] CSR_RUN_ON      = 3'd3;
   localparam logic [2:0] CSR_BISTABLE    = 3'd4;
   localparam logic [2:0] CSR_GROUP_LIST  = 3'd5;
   localparam logic [2:0] CSR_MUTE_GROUP  = 3'd6;

   localparam logic [7:0] UNUSED_GROUP = 8'hff;
   localparam logic [6:0] SECONDS_MASK = 7'h7f;

   // countdown / 60 as (countdown * 34953) >> 21, exact for 16-bit values
   localparam logic [32:0] MIN_RECIP = 33'd34953;
   localparam int          MIN_SHIFT = 21;

   typedef struct packed {
      logic [7:0] timer_code;
      logic       auto_off;
      logic       delayed_on;
      logic       run_on;
      logic       bistable;
   } mode_cfg_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [1:0]  mute_op;
      logic [7:0]  group;
      logic [1:0]  wake_mode;
      logic [15:0] alarm_seconds;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [7:0]  reply_group;
      logic        port_state;
      logic [7:0]  minutes_left;
      logic [15:0] countdown_value;
      logic        coil_level;
      logic        coil_pulse;
   } rsp_type;

endpackage

/* rtl/rptc_fifo.sv */
// ----------------------------------------------------------------------------
// rptc_fifo
// Small show-ahead queue; the oldest entry is on rd_data while not empty.
// ----------------------------------------------------------------------------
module rptc_fifo #(
   parameter int  DEPTH = 2,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_data,
   output logic      full,
   input  logic      pop,
   output entry_type rd_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/rptc_front.sv */
// ----------------------------------------------------------------------------
// rptc_front
// Accept input items, match groups and classify them into commands.
// ----------------------------------------------------------------------------
module rptc_front
   import rptc_pkg::*;
#(
   parameter int GROUP_COUNT = 8
) (
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_kind,
   input  logic [3:0]               req_msg_type,
   input  logic [7:0]               req_target_group,
   input  logic [1:0]               req_wake_mode,
   input  logic [15:0]              req_alarm_seconds,
   input  logic [GROUP_COUNT*8-1:0] group_list,
   input  logic [7:0]               mute_group,
   input  logic                     cmd_full,
   output logic                     cmd_push,
   output cmd_type                  cmd
);

   logic       group_hit;
   logic       primary_hit;
   logic [7:0] primary;

   assign primary     = group_list[7:0];
   assign primary_hit = (req_target_group == primary);
   assign req_full    = cmd_full;
   assign cmd_push    = req_push && !cmd_full;

   always_comb begin
      group_hit = 1'b0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
         if (group_list[8*i +: 8] == req_target_group) begin
            group_hit = 1'b1;
         end
      end
      if (req_target_group == UNUSED_GROUP) begin
         group_hit = 1'b0;
      end
   end

   always_comb begin
      cmd.op            = OP_NONE;
      cmd.mute_op       = MUTE_NONE;
      cmd.group         = req_target_group;
      cmd.wake_mode     = req_wake_mode;
      cmd.alarm_seconds = req_alarm_seconds;
      if (req_kind == KIND_TICK) begin
         cmd.op = OP_TICK;
      end else begin
         if (group_hit) begin
            unique case (req_msg_type)
               MT_BUTTON:     cmd.op = OP_BUTTON;
               MT_ON:         cmd.op = OP_ON;
               MT_OFF:        cmd.op = OP_OFF;
               MT_QUERY:      cmd.op = OP_QUERY;
               MT_CFG_REQ:    cmd.op = OP_CFG_REQ;
               MT_ALARM_SET:  cmd.op = primary_hit ? OP_ALARM_SET : OP_NONE;
               MT_ALARM_INFO: cmd.op = primary_hit ? OP_ALARM_INFO : OP_NONE;
               default:       cmd.op = OP_NONE;
            endcase
         end else if (req_msg_type == MT_DEV_STATES && primary != UNUSED_GROUP) begin
            cmd.op = OP_STATE_REPLY;
         end
         if (mute_group == req_target_group) begin
            if (req_msg_type == MT_MUTE_OFF) begin
               cmd.mute_op = MUTE_CLEAR;
            end else if (req_msg_type == MT_MUTE_ON) begin
               cmd.mute_op = MUTE_SET;
            end
         end
      end
   end

endmodule

/* rtl/rptc_back.sv */
// ----------------------------------------------------------------------------
// rptc_back
// Carry out commands: relay state, countdown, wake flags and replies.
// ----------------------------------------------------------------------------
module rptc_back
   import rptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   input  logic         out_full,
   output logic         out_push,
   output rsp_type      out_data,
   input  mode_cfg_type mode,
   input  logic [7:0]   primary
);

   logic        drive_ff, drive_in;
   logic        latch_ff, latch_in;
   logic        muted_ff, muted_in;
   logic        wake_on_ff, wake_on_in;
   logic        wake_off_ff, wake_off_in;
   logic [15:0] countdown_ff, countdown_in;

   logic        fire;
   logic        on_req, off_req, sw_on, sw_off, has_reply, pulse;
   logic [1:0]  kind;
   logic [7:0]  grp;
   logic [15:0] tc_ext;
   logic [15:0] reload_value;
   logic [32:0] mins_prod;
   logic [11:0] mins_quot;
   logic [7:0]  mins;
   logic        state_now;

   assign fire    = cmd_valid && !out_full;
   assign cmd_pop = fire;

   // seconds code or minutes times 60 (x*64 - x*4)
   assign tc_ext       = {8'b0, mode.timer_code};
   assign reload_value = mode.timer_code[7] ? {9'b0, mode.timer_code[6:0] & SECONDS_MASK}
                                            : (tc_ext << 6) - (tc_ext << 2);

   assign mins_prod = 33'(countdown_ff) * MIN_RECIP;
   assign mins_quot = mins_prod[MIN_SHIFT +: 12];
   assign mins      = (countdown_ff == '0) ? 8'd0 : mins_quot[7:0] + 8'd1;

   always_comb begin
      drive_in     = drive_ff;
      latch_in     = latch_ff;
      muted_in     = muted_ff;
      wake_on_in   = wake_on_ff;
      wake_off_in  = wake_off_ff;
      countdown_in = countdown_ff;
      on_req       = 1'b0;
      off_req      = 1'b0;
      sw_on        = 1'b0;
      sw_off       = 1'b0;
      has_reply    = 1'b0;
      pulse        = 1'b0;
      kind         = RK_BROADCAST;
      grp          = primary;
      if (fire) begin
         unique case (cmd.op)
            OP_TICK: begin
               if (countdown_ff == 16'd1) begin
                  if (wake_on_ff) begin
                     sw_on        = 1'b1;
                     wake_on_in   = 1'b0;
                     countdown_in = reload_value;
                  end else if (wake_off_ff) begin
                     sw_off      = 1'b1;
                     wake_off_in = 1'b0;
                  end else if (mode.delayed_on) begin
                     sw_on = 1'b1;
                  end else if (mode.auto_off || mode.run_on) begin
                     sw_off = 1'b1;
                  end
               end
               if (countdown_in != '0) begin
                  countdown_in = countdown_in - 16'd1;
               end
            end
            OP_BUTTON: begin
               on_req  = !muted_ff && !drive_ff;
               off_req = !muted_ff && drive_ff;
            end
            OP_ON:  on_req  = !muted_ff;
            OP_OFF: off_req = !muted_ff;
            OP_QUERY: begin
               has_reply = 1'b1;
               kind      = RK_STATE_REPLY;
               grp       = cmd.group;
            end
            OP_CFG_REQ: begin
               has_reply = 1'b1;
               kind      = RK_CFG_REPLY;
            end
            OP_ALARM_SET: begin
               if (cmd.wake_mode == WAKE_ON) begin
                  wake_on_in = 1'b1;
               end else if (cmd.wake_mode == WAKE_OFF) begin
                  wake_off_in = 1'b1;
               end
               countdown_in = cmd.alarm_seconds;
               sw_on        = wake_off_in;
            end
            OP_ALARM_INFO: begin
               has_reply = 1'b1;
               kind      = RK_ALARM_REPLY;
            end
            OP_STATE_REPLY: begin
               has_reply = 1'b1;
               kind      = RK_STATE_REPLY;
            end
            default: ;
         endcase

         if (on_req) begin
            if (mode.auto_off) begin
               sw_on        = 1'b1;
               countdown_in = reload_value;
            end else if (mode.delayed_on) begin
               countdown_in = reload_value;
            end else begin
               sw_on        = 1'b1;
               countdown_in = '0;
            end
         end
         if (off_req) begin
            if (mode.run_on) begin
               countdown_in = reload_value;
            end else begin
               sw_off       = 1'b1;
               countdown_in = '0;
            end
         end

         if (sw_on) begin
            if (mode.bistable) begin
               drive_in = 1'b0;
               latch_in = !latch_ff;
               pulse    = 1'b1;
            end else begin
               drive_in = 1'b1;
            end
         end
         if (sw_off) begin
            drive_in = 1'b0;
         end
         if (sw_on || sw_off) begin
            has_reply = 1'b1;
            kind      = RK_BROADCAST;
            grp       = primary;
         end

         case (cmd.mute_op)
            MUTE_CLEAR: muted_in = 1'b0;
            MUTE_SET:   muted_in = 1'b1;
            default:    muted_in = muted_ff;
         endcase
      end
   end

   assign state_now = mode.bistable ? latch_in : drive_in;

   always_comb begin
      out_push                 = fire && has_reply;
      out_data.reply_kind      = kind;
      out_data.reply_group     = grp;
      out_data.port_state      = (kind == RK_BROADCAST || kind == RK_STATE_REPLY) ?
                                 state_now : 1'b0;
      out_data.minutes_left    = (kind == RK_STATE_REPLY) ? mins : 8'd0;
      out_data.countdown_value = (kind == RK_ALARM_REPLY) ? countdown_ff : 16'd0;
      out_data.coil_level      = drive_in;
      out_data.coil_pulse      = pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= 1'b0;
         latch_ff     <= 1'b0;
         muted_ff     <= 1'b0;
         wake_on_ff   <= 1'b0;
         wake_off_ff  <= 1'b0;
         countdown_ff <= '0;
      end else begin
         drive_ff     <= drive_in;
         latch_ff     <= latch_in;
         muted_ff     <= muted_in;
         wake_on_ff   <= wake_on_in;
         wake_off_ff  <= wake_off_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

/* rtl/relay_port_timer_controller.sv */
// ----------------------------------------------------------------------------
// relay_port_timer_controller
// Relay port driven by group messages and one-second ticks.
// ----------------------------------------------------------------------------
// Path: the transfer edge writes the command queue; an edge with room in the
//   result queue carries the command through the back end into that queue.
// Throughput: one item per cycle while req_full is low; the back end updates
//   relay state and the countdown for one command per cycle while the result
//   queue is not full, and both queues decouple stalls.
// Reset: synchronous, active high; empties both queues, clears relay state
//   and countdown, and resets every register but the queue storage.
// ----------------------------------------------------------------------------
module relay_port_timer_controller
   import rptc_pkg::*;
#(
   parameter int GROUP_COUNT = 8,
   parameter int CMD_DEPTH   = 2,
   parameter int RSP_DEPTH   = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [3:0]  req_msg_type,
   input  logic [7:0]  req_target_group,
   input  logic [1:0]  req_wake_mode,
   input  logic [15:0] req_alarm_seconds,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_reply_kind,
   output logic [7:0]  rsp_reply_group,
   output logic        rsp_port_state,
   output logic [7:0]  rsp_minutes_left,
   output logic [15:0] rsp_countdown_value,
   output logic        rsp_coil_level,
   output logic        rsp_coil_pulse,
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration registers
   logic [7:0]               timer_code_ff;
   logic                     auto_off_ff;
   logic                     delayed_on_ff;
   logic                     run_on_ff;
   logic                     bistable_ff;
   logic [GROUP_COUNT*8-1:0] group_list_ff;
   logic [7:0]               mute_group_ff;

   mode_cfg_type mode;

   // front to back queue
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_wr, cmd_rd;

   // back to result queue
   logic    out_push, out_full;
   rsp_type out_wr, out_rd;

   // Hold register values; a write to an index outside the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_code_ff <= 8'd0;
         auto_off_ff   <= 1'b0;
         delayed_on_ff <= 1'b0;
         run_on_ff     <= 1'b0;
         bistable_ff   <= 1'b0;
         group_list_ff <= '1;
         mute_group_ff <= UNUSED_GROUP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMER_CODE: timer_code_ff <= csr_wdata[7:0];
            CSR_AUTO_OFF:   auto_off_ff   <= csr_wdata[0];
            CSR_DELAYED_ON: delayed_on_ff <= csr_wdata[0];
            CSR_RUN_ON:     run_on_ff     <= csr_wdata[0];
            CSR_BISTABLE:   bistable_ff   <= csr_wdata[0];
            // only the bytes the group compare looks at are kept
            CSR_GROUP_LIST: group_list_ff <= csr_wdata[GROUP_COUNT*8-1:0];
            CSR_MUTE_GROUP: mute_group_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign mode.timer_code = timer_code_ff;
   assign mode.auto_off   = auto_off_ff;
   assign mode.delayed_on = delayed_on_ff;
   assign mode.run_on     = run_on_ff;
   assign mode.bistable   = bistable_ff;

   // Front: classify each transfer by group match and message type.
   rptc_front #(
      .GROUP_COUNT (GROUP_COUNT)
   ) u_front (
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_msg_type      (req_msg_type),
      .req_target_group  (req_target_group),
      .req_wake_mode     (req_wake_mode),
      .req_alarm_seconds (req_alarm_seconds),
      .group_list        (group_list_ff),
      .mute_group        (mute_group_ff),
      .cmd_full          (cmd_full),
      .cmd_push          (cmd_push),
      .cmd               (cmd_wr)
   );

   // Command queue lets the front keep taking items while the back stalls.
   rptc_fifo #(
      .DEPTH      (CMD_DEPTH),
      .entry_type (cmd_type)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   // Back: advance relay state and countdown, build at most one reply.
   rptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wr),
      .mode      (mode),
      .primary   (group_list_ff[7:0])
   );

   // Result queue parts the back end from the consumer.
   rptc_fifo #(
      .DEPTH      (RSP_DEPTH),
      .entry_type (rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .empty   (rsp_empty)
   );

   assign rsp_reply_kind      = out_rd.reply_kind;
   assign rsp_reply_group     = out_rd.reply_group;
   assign rsp_port_state      = out_rd.port_state;
   assign rsp_minutes_left    = out_rd.minutes_left;
   assign rsp_countdown_value = out_rd.countdown_value;
   assign rsp_coil_level      = out_rd.coil_level;
   assign rsp_coil_pulse      = out_rd.coil_pulse;

endmodule

/* rtl/rptc_checker.sv */
// ----------------------------------------------------------------------------
// rptc_checker
// Port-level checks of the relay port timer controller, bound to its top.
// ----------------------------------------------------------------------------
`include "relay_port_timer_controller_macros.svh"

module rptc_checker
   import rptc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_reply_kind,
   input logic [15:0] rsp_countdown_value,
   input logic        rsp_coil_level,
   input logic        rsp_coil_pulse
);

   // reset leaves both channels drained
   `RPTC_ASSERT_RST(a_reset_drains, reset |=> rsp_empty && !req_full, "queues not empty after reset")

   // a waiting result stays until taken
   `RPTC_ASSERT(a_rsp_held, !rsp_empty && !rsp_pop |=> !rsp_empty, "result dropped before pop")

   // a coil pulse only comes with a broadcast and the steady drive off
   `RPTC_ASSERT(a_pulse_broadcast, !rsp_empty && rsp_coil_pulse |-> !rsp_coil_level && rsp_reply_kind == RK_BROADCAST, "coil pulse on wrong result")

   // raw countdown only travels in alarm details replies
   `RPTC_ASSERT(a_count_only_alarm, !rsp_empty && rsp_reply_kind != RK_ALARM_REPLY |-> rsp_countdown_value == 16'd0, "countdown leaked into reply")

endmodule

bind relay_port_timer_controller rptc_checker u_checker (.*);

/* dv/relay_port_timer_controller_test.sv */
// ----------------------------------------------------------------------------
// relay_port_timer_controller_test
// Self-checking bench for the relay port timer controller. A bursty driver
// feeds ticks and group messages from a queue. A stalling receiver drains
// the results. A clocked monitor runs a cycle-free model of relay, countdown
// and mute state on every input transfer. It checks each result transfer
// field by field against the oldest predicted reply. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module relay_port_timer_controller_test
   import rptc_pkg::*;
();

   localparam int GROUPS        = 8;
   localparam int WATCHDOG_SPAN = 3000;   // cycles without any transfer
   localparam int HOLD_AFTER    = 300;    // results checked before the long hold
   localparam int HOLD_SPAN     = 160;    // cycles of the long hold
   localparam int HOLD_BACKLOG  = 20;     // items still waiting when the hold starts
   localparam int PHASE_ITEMS   = 150;
   localparam int RANDOM_PHASES = 9;

   localparam logic [2:0] CSR_SPARE = 3'd7;        // index outside the register list
   localparam logic [3:0] MT_SPARE  = 4'd15;       // message type that nobody handles
   localparam logic [1:0] WAKE_NONE = 2'd0;
   localparam logic [1:0] WAKE_BOTH = 2'd3;        // sets no flag, still loads

   // receiver pop patterns
   localparam int POP_STEADY = 0;
   localparam int POP_RANDOM = 1;
   localparam int POP_STALL  = 2;

   typedef struct packed {
      logic        kind;
      logic [3:0]  msg_type;
      logic [7:0]  target_group;
      logic [1:0]  wake_mode;
      logic [15:0] alarm_seconds;
   } relay_item_type;

   // ------------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = 1'b0;
   logic [3:0]  req_msg_type = '0;
   logic [7:0]  req_target_group = '0;
   logic [1:0]  req_wake_mode = '0;
   logic [15:0] req_alarm_seconds = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_reply_kind;
   logic [7:0]  rsp_reply_group;
   logic        rsp_port_state;
   logic [7:0]  rsp_minutes_left;
   logic [15:0] rsp_countdown_value;
   logic        rsp_coil_level;
   logic        rsp_coil_pulse;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   always #6 clock = ~clock;

   relay_port_timer_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_msg_type        (req_msg_type),
      .req_target_group    (req_target_group),
      .req_wake_mode       (req_wake_mode),
      .req_alarm_seconds   (req_alarm_seconds),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_reply_kind      (rsp_reply_kind),
      .rsp_reply_group     (rsp_reply_group),
      .rsp_port_state      (rsp_port_state),
      .rsp_minutes_left    (rsp_minutes_left),
      .rsp_countdown_value (rsp_countdown_value),
      .rsp_coil_level      (rsp_coil_level),
      .rsp_coil_pulse      (rsp_coil_pulse),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // bench bookkeeping
   // ------------------------------------------------------------------------
   relay_item_type pending_items[$];   // filled by the sequence, drained by the driver
   rsp_type        awaited_replies[$]; // predicted results, oldest first
   int          items_queued    = 0;
   int          items_accepted  = 0;
   int          replies_checked = 0;
   int          error_count     = 0;
   int          idle_cycles     = 0;
   logic        req_took        = 1'b0;

   // group ids and mute id of the current phase, used to aim random targets
   logic [63:0] phase_groups = '1;
   logic [7:0]  phase_mute   = UNUSED_GROUP;

   // ------------------------------------------------------------------------
   // relay model: register copy and state, updated once per transfer
   // ------------------------------------------------------------------------
   logic [7:0]  cfg_timer_code  = '0;
   logic        cfg_auto_off    = 1'b0;
   logic        cfg_delayed_on  = 1'b0;
   logic        cfg_run_on      = 1'b0;
   logic        cfg_bistable    = 1'b0;
   logic [63:0] cfg_groups      = '1;
   logic [7:0]  cfg_mute_group  = UNUSED_GROUP;

   logic        relay_drive     = 1'b0;
   logic        relay_latch     = 1'b0;
   logic        port_muted      = 1'b0;
   logic        wake_on_armed   = 1'b0;
   logic        wake_off_armed  = 1'b0;
   logic [15:0] seconds_left    = '0;

   logic        reply_made;
   logic        coil_pulsed;
   rsp_type     reply_word;

   function automatic logic [7:0] primary_group();
      return cfg_groups[7:0];
   endfunction

   // latching relays report the remembered position, others the drive
   function automatic logic reported_state();
      return cfg_bistable ? relay_latch : relay_drive;
   endfunction

   function automatic logic [7:0] minutes_remaining();
      logic [15:0] whole;
      if (seconds_left == 16'd0) return 8'd0;
      whole = seconds_left / 16'd60 + 16'd1;
      return whole[7:0];
   endfunction

   function automatic logic group_hit(logic [7:0] grp);
      if (grp == UNUSED_GROUP) return 1'b0;
      for (int i = 0; i < GROUPS; i++)
         if (cfg_groups[8*i +: 8] == grp) return 1'b1;
      return 1'b0;
   endfunction

   task automatic make_reply(logic [1:0] rkind, logic [7:0] grp, logic st,
                             logic [7:0] mins, logic [15:0] secs);
      reply_made                 = 1'b1;
      reply_word                 = '0;
      reply_word.reply_kind      = rkind;
      reply_word.reply_group     = grp;
      reply_word.port_state      = st;
      reply_word.minutes_left    = mins;
      reply_word.countdown_value = secs;
   endtask

   // seconds code loads as is, minutes code times 60; a zero code loads zero
   task automatic reload_countdown();
      if (cfg_timer_code[7]) seconds_left = {9'd0, cfg_timer_code[6:0]};
      else seconds_left = 16'(cfg_timer_code) * 16'd60;
   endtask

   task automatic relay_on();
      if (cfg_bistable) begin
         relay_drive = 1'b0;
         relay_latch = ~relay_latch;
         coil_pulsed = 1'b1;
      end else begin
         relay_drive = 1'b1;
      end
      make_reply(RK_BROADCAST, primary_group(), reported_state(), 8'd0, 16'd0);
   endtask

   task automatic relay_off();
      relay_drive = 1'b0;
      make_reply(RK_BROADCAST, primary_group(), reported_state(), 8'd0, 16'd0);
   endtask

   task automatic on_request();
      if (cfg_auto_off) begin
         relay_on();
         reload_countdown();
      end else if (cfg_delayed_on) begin
         reload_countdown();
      end else begin
         relay_on();
         seconds_left = '0;
      end
   endtask

   task automatic off_request();
      if (cfg_run_on) begin
         reload_countdown();
      end else begin
         relay_off();
         seconds_left = '0;
      end
   endtask

   // expiry acts on the wake flags first, then on the mode
   task automatic one_second();
      if (seconds_left == 16'd1) begin
         if (wake_on_armed) begin
            relay_on();
            wake_on_armed = 1'b0;
            reload_countdown();
         end else if (wake_off_armed) begin
            relay_off();
            wake_off_armed = 1'b0;
         end else if (cfg_delayed_on) begin
            relay_on();
         end else if (cfg_auto_off || cfg_run_on) begin
            relay_off();
         end
      end
      if (seconds_left != 16'd0) seconds_left--;
   endtask

   task automatic handle_message(relay_item_type it);
      if (group_hit(it.target_group)) begin
         case (it.msg_type)
            MT_BUTTON: begin
               if (!port_muted) begin
                  if (relay_drive) off_request();
                  else on_request();
               end
            end
            MT_ON: if (!port_muted) on_request();
            MT_OFF: if (!port_muted) off_request();
            MT_QUERY: begin
               make_reply(RK_STATE_REPLY, it.target_group, reported_state(),
                          minutes_remaining(), 16'd0);
            end
            MT_CFG_REQ: make_reply(RK_CFG_REPLY, primary_group(), 1'b0, 8'd0, 16'd0);
            MT_ALARM_SET: begin
               if (primary_group() == it.target_group) begin
                  if (it.wake_mode == WAKE_ON) wake_on_armed = 1'b1;
                  else if (it.wake_mode == WAKE_OFF) wake_off_armed = 1'b1;
                  seconds_left = it.alarm_seconds;
                  if (wake_off_armed) relay_on();
               end
            end
            MT_ALARM_INFO: begin
               if (primary_group() == it.target_group)
                  make_reply(RK_ALARM_REPLY, primary_group(), 1'b0, 8'd0, seconds_left);
            end
            default: ;
         endcase
      end else if (it.msg_type == MT_DEV_STATES) begin
         // answer for the primary group when the message is not for us
         if (primary_group() != UNUSED_GROUP)
            make_reply(RK_STATE_REPLY, primary_group(), reported_state(),
                       minutes_remaining(), 16'd0);
      end
      if (cfg_mute_group == it.target_group) begin
         if (it.msg_type == MT_MUTE_OFF) port_muted = 1'b0;
         else if (it.msg_type == MT_MUTE_ON) port_muted = 1'b1;
      end
   endtask

   task automatic relay_predict(relay_item_type it);
      reply_made  = 1'b0;
      coil_pulsed = 1'b0;
      if (it.kind == KIND_TICK) one_second();
      else handle_message(it);
      if (reply_made) begin
         reply_word.coil_level = relay_drive;
         reply_word.coil_pulse = coil_pulsed;
         awaited_replies.push_back(reply_word);
      end
   endtask

   task automatic apply_register(logic [2:0] idx, logic [63:0] value);
      case (idx)
         CSR_TIMER_CODE: cfg_timer_code = value[7:0];
         CSR_AUTO_OFF:   cfg_auto_off   = value[0];
         CSR_DELAYED_ON: cfg_delayed_on = value[0];
         CSR_RUN_ON:     cfg_run_on     = value[0];
         CSR_BISTABLE:   cfg_bistable   = value[0];
         CSR_GROUP_LIST: cfg_groups     = value;
         CSR_MUTE_GROUP: cfg_mute_group = value[7:0];
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // monitor: sample both channels and the register port at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type        want;
      relay_item_type seen;
      if (reset) begin
         req_took    <= 1'b0;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         // register writes only land while idle, so order against transfers is moot
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (req_push && !req_full) begin
            seen.kind          = req_kind;
            seen.msg_type      = req_msg_type;
            seen.target_group  = req_target_group;
            seen.wake_mode     = req_wake_mode;
            seen.alarm_seconds = req_alarm_seconds;
            relay_predict(seen);
            items_accepted++;
            idle_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            idle_cycles = 0;
            if (awaited_replies.size() == 0) begin
               $error("unexpected result transfer: reply_kind %0d, reply_group 0x%0h",
                      rsp_reply_kind, rsp_reply_group);
               error_count++;
            end else begin
               want = awaited_replies.pop_front();
               check_field("reply_kind", want.reply_kind, rsp_reply_kind);
               check_field("reply_group", want.reply_group, rsp_reply_group);
               check_field("port_state", want.port_state, rsp_port_state);
               check_field("minutes_left", want.minutes_left, rsp_minutes_left);
               check_field("countdown_value", want.countdown_value, rsp_countdown_value);
               check_field("coil_level", want.coil_level, rsp_coil_level);
               check_field("coil_pulse", want.coil_pulse, rsp_coil_pulse);
               replies_checked++;
            end
         end
         req_took <= req_push && !req_full;
      end
   end

   // ------------------------------------------------------------------------
   // driver: bursts of transfers separated by random gaps
   // ------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      relay_item_type item_out;
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_took) begin
         // hold the current item until its transfer, then advance
         if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_push <= 1'b0;
         end else begin
            item_out = pending_items.pop_front();
            req_push          <= 1'b1;
            req_kind          <= item_out.kind;
            req_msg_type      <= item_out.msg_type;
            req_target_group  <= item_out.target_group;
            req_wake_mode     <= item_out.wake_mode;
            req_alarm_seconds <= item_out.alarm_seconds;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // a quarter of the bursts run straight into the next one
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: own stall pattern, plus one long hold that fills the block
   // ------------------------------------------------------------------------
   int   pop_style = POP_STEADY;
   int   pop_left  = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (!hold_done && replies_checked >= HOLD_AFTER &&
                   pending_items.size() >= HOLD_BACKLOG) begin
         // hold off while the driver keeps offering, so req_full must rise
         hold_done = 1'b1;
         hold_left = HOLD_SPAN;
         rsp_pop <= 1'b0;
      end else begin
         if (pop_left == 0) begin
            pop_style = $urandom_range(POP_STEADY, POP_STALL);
            pop_left  = $urandom_range(1, 16);
         end
         pop_left--;
         case (pop_style)
            POP_STEADY: rsp_pop <= 1'b1;
            POP_RANDOM: rsp_pop <= 1'($urandom_range(0, 1));
            default:    rsp_pop <= 1'b0;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: end the run when transfers stop for too long
   // ------------------------------------------------------------------------
   initial begin
      while (idle_cycles < WATCHDOG_SPAN) @(negedge clock);
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   task automatic queue_item(relay_item_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic send_tick();
      relay_item_type it;
      it      = relay_item_type'({$urandom(), $urandom()});
      it.kind = KIND_TICK;
      queue_item(it);
   endtask

   task automatic send_message(logic [3:0] mt, logic [7:0] grp, logic [1:0] wake,
                               logic [15:0] secs);
      relay_item_type it;
      it.kind          = KIND_MESSAGE;
      it.msg_type      = mt;
      it.target_group  = grp;
      it.wake_mode     = wake;
      it.alarm_seconds = secs;
      queue_item(it);
   endtask

   // wait until every item is in and every reply is out, then let the
   // pipeline settle in case the last items made no reply
   task automatic drain();
      do @(negedge clock);
      while (items_accepted != items_queued || awaited_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // enables: auto-off, delayed-on, run-on, bistable from high to low bit
   task automatic set_mode(logic [7:0] timer, logic [3:0] enables, logic [63:0] groups,
                           logic [7:0] mute_id);
      drain();
      // unused data bits carry random values; the block must drop them
      write_register(CSR_TIMER_CODE, {$urandom(), 24'($urandom()), timer});
      write_register(CSR_AUTO_OFF, {$urandom(), 31'($urandom()), enables[3]});
      write_register(CSR_DELAYED_ON, {$urandom(), 31'($urandom()), enables[2]});
      write_register(CSR_RUN_ON, {$urandom(), 31'($urandom()), enables[1]});
      write_register(CSR_BISTABLE, {$urandom(), 31'($urandom()), enables[0]});
      write_register(CSR_GROUP_LIST, groups);
      write_register(CSR_MUTE_GROUP, {$urandom(), 24'($urandom()), mute_id});
      write_register(CSR_SPARE, {$urandom(), $urandom()});
      @(negedge clock);
      csr_we <= 1'b0;
      phase_groups = groups;
      phase_mute   = mute_id;
   endtask

   function automatic logic [63:0] random_groups();
      logic [63:0] groups;
      for (int i = 0; i < GROUPS; i++)
         groups[8*i +: 8] = ($urandom_range(0, 5) == 0) ? UNUSED_GROUP
                                                       : 8'($urandom_range(0, 255));
      return groups;
   endfunction

   // mostly short second counts so that expiry comes often
   function automatic logic [7:0] random_timer();
      if ($urandom_range(0, 9) < 7) return {1'b1, 7'($urandom_range(0, 5))};
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic relay_item_type random_item();
      relay_item_type it;
      int             pick;
      it   = relay_item_type'({$urandom(), $urandom()});
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         it.kind = KIND_TICK;
         return it;
      end
      it.kind     = KIND_MESSAGE;
      it.msg_type = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
      pick = $urandom_range(0, 99);
      if (pick < 60)      it.target_group = phase_groups[8*$urandom_range(0, GROUPS-1) +: 8];
      else if (pick < 72) it.target_group = phase_groups[7:0];
      else if (pick < 80) it.target_group = phase_mute;
      else if (pick < 86) it.target_group = UNUSED_GROUP;
      else                it.target_group = 8'($urandom_range(0, 255));
      it.wake_mode = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) it.alarm_seconds = 16'($urandom_range(0, 6));
      return it;
   endfunction

   initial begin
      logic [7:0]  timer;
      logic [3:0]  enables;
      logic [63:0] groups;
      logic [7:0]  mute_id;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: no group in the list, so nothing matches
      send_message(MT_DEV_STATES, 8'h00, WAKE_NONE, 16'd0);
      send_message(MT_ON, UNUSED_GROUP, WAKE_NONE, 16'd0);
      send_tick();

      // auto-off with a two second timer
      set_mode(8'h82, 4'b1000, 64'hFFFF_FFFF_FF30_2010, 8'h40);
      send_message(MT_ON, 8'h10, WAKE_NONE, 16'd0);
      send_message(MT_QUERY, 8'h20, WAKE_NONE, 16'd0);
      send_tick();
      send_tick();                                        // expiry drops the relay
      send_message(MT_BUTTON, 8'h30, WAKE_NONE, 16'd0);   // off, so acts as on
      send_message(MT_BUTTON, 8'h30, WAKE_NONE, 16'd0);   // on, so acts as off
      send_message(MT_CFG_REQ, 8'h20, WAKE_NONE, 16'd0);
      send_message(MT_ALARM_SET, 8'h10, WAKE_OFF, 16'hFFFF);
      send_message(MT_ALARM_INFO, 8'h10, WAKE_NONE, 16'd0);
      send_message(MT_QUERY, 8'h10, WAKE_NONE, 16'd0);    // minutes wrap to 8 bits
      send_message(MT_ALARM_SET, 8'h20, WAKE_ON, 16'd7);  // not the primary group
      send_message(MT_DEV_STATES, 8'h20, WAKE_NONE, 16'd0);
      send_message(MT_DEV_STATES, 8'h55, WAKE_NONE, 16'd0);
      send_message(MT_MUTE_ON, 8'h40, WAKE_NONE, 16'd0);
      send_message(MT_OFF, 8'h10, WAKE_NONE, 16'd0);      // dropped while muted
      send_message(MT_MUTE_OFF, 8'h40, WAKE_NONE, 16'd0);
      send_message(MT_SPARE, 8'h10, WAKE_NONE, 16'd0);
      send_message(MT_ALARM_SET, 8'h10, WAKE_BOTH, 16'd3);

      // zero timer code: a wake reload must stay at zero
      set_mode(8'h00, 4'b0111, 64'hFFFF_FFFF_FF30_2010, UNUSED_GROUP);
      send_message(MT_ALARM_SET, 8'h10, WAKE_ON, 16'd1);
      send_tick();
      send_message(MT_ON, 8'h10, WAKE_NONE, 16'd0);
      send_message(MT_OFF, 8'h10, WAKE_NONE, 16'd0);
      send_message(MT_MUTE_ON, UNUSED_GROUP, WAKE_NONE, 16'd0);

      // random phases, the extremes first
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         timer   = random_timer();
         enables = 4'($urandom_range(0, 15));
         groups  = random_groups();
         mute_id = ($urandom_range(0, 1) == 0) ? groups[8*$urandom_range(0, GROUPS-1) +: 8]
                                              : 8'($urandom_range(0, 255));
         case (p)
            0: begin
               timer   = 8'h00;
               enables = 4'b0000;
               groups  = 64'h0;
               mute_id = 8'h00;
            end
            1: begin
               timer   = 8'hFF;
               enables = 4'b1111;
               mute_id = UNUSED_GROUP;
            end
            2: begin
               timer  = 8'h80;
               groups = '1;
            end
            3: timer = 8'h7F;
            default: ;
         endcase
         set_mode(timer, enables, groups, mute_id);
         repeat (PHASE_ITEMS) queue_item(random_item());
      end

      drain();
      repeat (8) @(negedge clock);
      if (error_count == 0 && awaited_replies.size() == 0 && rsp_empty)
         $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rptc_pkg.sv
rtl/rptc_fifo.sv
rtl/rptc_front.sv
rtl/rptc_back.sv
rtl/relay_port_timer_controller.sv
rtl/rptc_checker.sv
dv/relay_port_timer_controller_test.sv
